FILE: rtl/core/xtnc_pkg.sv
package xtnc_pkg;

    // Default capacity of the tag stack
    localparam int DEF_MAX_DEPTH    = 32;
    localparam int DEF_MAX_NAME_LEN = 16;

    // Markup characters
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Scanner modes
    localparam logic [1:0] MODE_OUTSIDE  = 2'd0;
    localparam logic [1:0] MODE_AFTER_LT = 2'd1;
    localparam logic [1:0] MODE_CLOSING  = 2'd2;
    localparam logic [1:0] MODE_OPENING  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_NESTING  = 2'd1;
    localparam logic [1:0] ST_ACCEPTED = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] open_depth;
    } result_item_t;

endpackage

FILE: rtl/core/xml_tag_nesting_checker.sv
// A character transaction is captured in the input register; its result is then held in the result register.
// Throughput: one character per cycle while result_stall does not hold the pipe; the stack-top name byte and length are
// prefetched from the name RAMs using the next scanner state, so each closing
// name byte is compared in the cycle it is processed.
// Reset: rst_n clears the scanner, stack depth, error latch and pipeline valids at
// once; the name RAMs are not cleared and their contents are only used where already written.
module xml_tag_nesting_checker
    import xtnc_pkg::*;
#(
    parameter int MAX_DEPTH    = DEF_MAX_DEPTH,
    parameter int MAX_NAME_LEN = DEF_MAX_NAME_LEN
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_item_t   char_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int NW = $clog2(MAX_NAME_LEN + 1);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int IW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int STORE_DEPTH = 2 ** (SW + IW);
    localparam int LEN_DEPTH   = 2 ** SW;

    // Pipeline registers
    logic         in_valid_reg;
    char_item_t   in_item_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    result_item_t out_item_next;

    // Scanner state
    logic [1:0]    mode_reg, mode_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [NW-1:0] index_reg, index_next;
    logic          differs_reg, differs_next;
    logic [1:0]    err_reg, err_next;

    // Name RAM ports
    logic          store_wr_en;
    logic [SW+IW-1:0] store_wr_addr, store_rd_addr;
    logic [7:0]    store_rd_data;
    logic          len_wr_en;
    logic [SW-1:0] len_wr_addr, len_rd_addr;
    logic [NW-1:0] len_rd_data;
    logic          byp_valid_reg;
    logic [NW-1:0] byp_len_reg;
    logic [NW-1:0] top_len;

    logic          advance;
    logic          proc_fire;
    logic [DW-1:0] depth_dec;
    logic [DW-1:0] depth_next_dec;
    logic [1:0]    status;
    logic [DW+5:0] depth_ext;
    logic [7:0]    c;
    logic          take_byte;
    logic [1:0]    take_mode;

    // Handshake: the whole pipe moves when the result slot is free or drained
    assign advance      = !out_valid_reg || !result_stall;
    assign proc_fire    = in_valid_reg && advance;
    assign char_stall   = in_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // Hold the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_item_reg <= char_item;
        end
    end

    // Stack top length, with bypass for a push just written
    assign top_len   = byp_valid_reg ? byp_len_reg : len_rd_data;
    assign depth_dec = depth_reg - 1'b1;
    assign c         = in_item_reg.char_in;

    // Process one character
    always_comb
    begin
        mode_next    = mode_reg;
        depth_next   = depth_reg;
        index_next   = index_reg;
        differs_next = differs_reg;
        err_next     = err_reg;
        store_wr_en  = 1'b0;
        len_wr_en    = 1'b0;
        take_byte    = 1'b0;
        take_mode    = mode_reg;
        status       = err_reg;
        out_item_next = out_item_reg;

        if (proc_fire)
        begin
            if (err_reg == ST_RUNNING)
            begin
                if (c == CHAR_LT)
                begin
                    mode_next    = MODE_AFTER_LT;
                    index_next   = '0;
                    differs_next = 1'b0;
                end
                else if (c == CHAR_GT)
                begin
                    if (mode_reg == MODE_OPENING)
                    begin
                        if (depth_reg >= DW'(MAX_DEPTH))
                        begin
                            err_next = ST_CAPACITY;
                        end
                        else
                        begin
                            len_wr_en  = 1'b1;
                            depth_next = depth_reg + 1'b1;
                            mode_next  = MODE_OUTSIDE;
                        end
                    end
                    else if (mode_reg == MODE_CLOSING)
                    begin
                        if (depth_reg == '0 || differs_reg || index_reg != top_len)
                        begin
                            err_next = ST_NESTING;
                        end
                        else
                        begin
                            depth_next = depth_dec;
                            mode_next  = MODE_OUTSIDE;
                        end
                    end
                end
                else if (mode_reg == MODE_AFTER_LT)
                begin
                    if (c == CHAR_SLASH)
                    begin
                        mode_next = MODE_CLOSING;
                    end
                    else
                    begin
                        mode_next = MODE_OPENING;
                        take_byte = 1'b1;
                        take_mode = MODE_OPENING;
                    end
                end
                else if (mode_reg == MODE_OPENING || mode_reg == MODE_CLOSING)
                begin
                    take_byte = 1'b1;
                end

                // Store or compare one name byte
                if (take_byte)
                begin
                    if (index_reg >= NW'(MAX_NAME_LEN))
                    begin
                        err_next = ST_CAPACITY;
                    end
                    else
                    begin
                        if (take_mode == MODE_OPENING)
                        begin
                            store_wr_en = (depth_reg < DW'(MAX_DEPTH));
                        end
                        else if (depth_reg == '0 || index_reg >= top_len ||
                                 store_rd_data != c)
                        begin
                            differs_next = 1'b1;
                        end
                        index_next = index_reg + 1'b1;
                    end
                end
            end

            // Form the result
            status = err_next;
            if (in_item_reg.last_char && status == ST_RUNNING)
            begin
                status = (depth_next == '0) ? ST_ACCEPTED : ST_NESTING;
            end
            depth_ext = {6'd0, depth_next};
            out_item_next.status     = status;
            out_item_next.open_depth = depth_ext[5:0];

            // Clear after the final character
            if (in_item_reg.last_char)
            begin
                mode_next    = MODE_OUTSIDE;
                depth_next   = '0;
                index_next   = '0;
                differs_next = 1'b0;
                err_next     = ST_RUNNING;
            end
        end
        else
        begin
            depth_ext = {6'd0, depth_reg};
        end
    end

    // RAM addresses: write at the open slot, prefetch the next stack top
    assign depth_next_dec = depth_next - 1'b1;
    assign store_wr_addr  = {depth_reg[SW-1:0], index_reg[IW-1:0]};
    assign store_rd_addr  = {depth_next_dec[SW-1:0], index_next[IW-1:0]};
    assign len_wr_addr    = depth_reg[SW-1:0];
    assign len_rd_addr    = depth_next_dec[SW-1:0];

    // Advance scanner state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OUTSIDE;
            depth_reg     <= '0;
            index_reg     <= '0;
            differs_reg   <= 1'b0;
            err_reg       <= ST_RUNNING;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            depth_reg     <= depth_next;
            index_reg     <= index_next;
            differs_reg   <= differs_next;
            err_reg       <= err_next;
            byp_valid_reg <= len_wr_en && (len_wr_addr == len_rd_addr);
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        byp_len_reg  <= index_reg;
    end

    // Name bytes of every stacked tag
    xtnc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_name_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (c),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data)
    );

    // Name length of every stacked tag
    xtnc_ram #(
        .WIDTH (NW),
        .DEPTH (LEN_DEPTH)
    ) u_name_len (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (index_reg),
        .rd_addr (len_rd_addr),
        .rd_data (len_rd_data)
    );

endmodule

FILE: rtl/core/xtnc_ram.sv
module xtnc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, read before write
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
